// ===== rtl/coin_slot_credit_controller_defines.svh =====
// assertion macros for the coin slot credit controller checker
// no dependencies; included by the checker file only
`ifndef COIN_SLOT_CREDIT_CONTROLLER_DEFINES_SVH
`define COIN_SLOT_CREDIT_CONTROLLER_DEFINES_SVH

// same-cycle implication under reset
`define CSCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cscc check failed");

// next-cycle implication under reset
`define CSCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cscc check failed");

`endif

// ===== rtl/cscc_pkg.sv =====
// shared types, constants and the coin/credit cost table
// no dependencies
package cscc_pkg;

	localparam int HOLD_W    = 7;
	localparam int PULSE_W   = 5;
	localparam int PEND_W    = 8;
	localparam int COIN_W    = 3;
	localparam int CREDIT_W  = 4;
	localparam int TOTAL_W   = 16;
	localparam int SOUND_W   = 4;
	localparam int PAT_W     = 4;
	localparam int ROW_W     = 3;
	localparam int GRANT_W   = 3;

	localparam logic [PAT_W-1:0] ARM_PATTERN    = 4'h3;
	localparam logic [PAT_W-1:0] ACCEPT_PATTERN = 4'hc;

	localparam logic [PEND_W-1:0]  PEND_MAX  = '1;
	localparam logic [COIN_W-1:0]  COIN_MAX  = '1;
	localparam logic [SOUND_W-1:0] SOUND_MAX = '1;

	typedef enum logic [1:0] {
		REG_SLOT_ONE_COST = 2'd0,
		REG_SLOT_TWO_COST = 2'd1,
		REG_TWO_TO_START  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [COIN_W-1:0]  coins;
		logic [GRANT_W-1:0] credits;
	} cost_t;

	typedef struct packed {
		logic               coin;
		logic [GRANT_W-1:0] grant;
	} lane_evt_t;

	typedef struct packed {
		logic [CREDIT_W-1:0] credit_count;
		logic                counter_drive_one;
		logic                counter_drive_two;
		logic                coin_lock_enable;
		logic                sound_pulse;
		logic [TOTAL_W-1:0]  coins_taken;
	} result_t;

	function automatic cost_t cost_lookup(logic [ROW_W-1:0] row);
		cost_t c;
		case (row)
			3'd0: c = '{coins: 3'd1, credits: 3'd1};
			3'd1: c = '{coins: 3'd1, credits: 3'd2};
			3'd2: c = '{coins: 3'd1, credits: 3'd3};
			3'd3: c = '{coins: 3'd1, credits: 3'd4};
			3'd4: c = '{coins: 3'd1, credits: 3'd6};
			3'd5: c = '{coins: 3'd2, credits: 3'd1};
			3'd6: c = '{coins: 3'd3, credits: 3'd1};
			3'd7: c = '{coins: 3'd4, credits: 3'd1};
			default: c = '{coins: 3'd1, credits: 3'd1};
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/cscc_lane.sv =====
// one coin slot lane: arm/accept detection, holdoff, counter pulse queue, cost counting
// depends on cscc_pkg
module cscc_lane import cscc_pkg::*; #(
	parameter int HOLDOFF_TICKS = 120,
	parameter int PULSE_PERIOD  = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [PAT_W-1:0] pattern,
	input  logic [ROW_W-1:0] cost_row,
	input  logic             two_to_start,
	output lane_evt_t        evt,
	output logic             drive
);

	logic               armed_q, armed_d;
	logic [HOLD_W-1:0]  hold_q, hold_d, hold_dec;
	logic [PULSE_W-1:0] timer_q, timer_d, timer_step;
	logic [PEND_W-1:0]  pend_q, pend_d, pend_mid;
	logic [COIN_W-1:0]  cc_q, cc_d, cc_inc;
	logic               accept;
	cost_t              cost;

	assign cost = cost_lookup(cost_row);

	always_comb begin
		timer_step = timer_q;
		pend_mid   = pend_q;
		if (timer_q != '0) begin
			timer_step = timer_q - PULSE_W'(1);
		end else if (pend_q != '0) begin
			pend_mid   = pend_q - PEND_W'(1);
			timer_step = PULSE_W'(PULSE_PERIOD);
		end
	end

	assign accept   = armed_q && (pattern == ACCEPT_PATTERN);
	assign hold_dec = hold_q - HOLD_W'(1);
	assign cc_inc   = (cc_q == COIN_MAX) ? cc_q : cc_q + COIN_W'(1);

	always_comb begin
		armed_d   = armed_q;
		hold_d    = hold_q;
		timer_d   = timer_q;
		pend_d    = pend_q;
		cc_d      = cc_q;
		evt.coin  = 1'b0;
		evt.grant = '0;
		if (step) begin
			timer_d = timer_step;
			pend_d  = pend_mid;
			if (!armed_q) begin
				if (pattern == ARM_PATTERN) begin
					armed_d = 1'b1;
					hold_d  = HOLD_W'(HOLDOFF_TICKS);
				end
			end else if (accept) begin
				armed_d  = 1'b0;
				evt.coin = 1'b1;
				pend_d   = (pend_mid == PEND_MAX) ? pend_mid : pend_mid + PEND_W'(1);
				if (two_to_start || cc_inc >= cost.coins) begin
					evt.grant = cost.credits;
					cc_d      = '0;
				end else begin
					cc_d = cc_inc;
				end
			end else begin
				hold_d = hold_dec;
				if (hold_dec == '0) begin
					armed_d = 1'b0;
				end
			end
		end
	end

	assign drive = timer_d > PULSE_W'(PULSE_PERIOD / 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			hold_q  <= '0;
			timer_q <= '0;
			pend_q  <= '0;
			cc_q    <= '0;
		end else begin
			armed_q <= armed_d;
			hold_q  <= hold_d;
			timer_q <= timer_d;
			pend_q  <= pend_d;
			cc_q    <= cc_d;
		end
	end

endmodule

// ===== rtl/cscc_merge.sv =====
// merge stage: credit total, service switch, coin total and sound queue
// depends on cscc_pkg
module cscc_merge import cscc_pkg::*; #(
	parameter int MAX_CREDITS = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                step,
	input  logic [PAT_W-1:0]    service_pattern,
	input  lane_evt_t           evt_one,
	input  lane_evt_t           evt_two,
	output logic [CREDIT_W-1:0] credit_count,
	output logic                coin_lock_enable,
	output logic                sound_pulse,
	output logic [TOTAL_W-1:0]  coins_taken
);

	localparam logic [CREDIT_W-1:0] CREDIT_LIMIT = CREDIT_W'(MAX_CREDITS);

	logic [CREDIT_W-1:0]  credits_q, credits_d, credits_slots;
	logic [TOTAL_W-1:0]   total_q, total_d;
	logic [SOUND_W-1:0]   sound_q, sound_d, sound_sat;
	logic [CREDIT_W:0]    credit_sum;
	logic [SOUND_W:0]     sound_sum;
	logic                 svc, svc_ok;

	assign credit_sum = {1'b0, credits_q} + (CREDIT_W+1)'(evt_one.grant)
		+ (CREDIT_W+1)'(evt_two.grant);
	assign credits_slots = (credit_sum > {1'b0, CREDIT_LIMIT}) ? CREDIT_LIMIT
		: credit_sum[CREDIT_W-1:0];
	assign svc       = step && (service_pattern == ARM_PATTERN);
	assign svc_ok    = svc && (credits_slots < CREDIT_LIMIT);
	assign credits_d = credits_slots + CREDIT_W'(svc_ok);
	assign total_d   = total_q + TOTAL_W'(evt_one.coin) + TOTAL_W'(evt_two.coin)
		+ TOTAL_W'(svc_ok);
	assign sound_sum = {1'b0, sound_q} + (SOUND_W+1)'(evt_one.coin)
		+ (SOUND_W+1)'(evt_two.coin) + (SOUND_W+1)'(svc);
	assign sound_sat = (sound_sum > {1'b0, SOUND_MAX}) ? SOUND_MAX : sound_sum[SOUND_W-1:0];
	assign sound_pulse = sound_sat != '0;
	assign sound_d     = sound_pulse ? sound_sat - SOUND_W'(1) : sound_sat;

	assign credit_count     = credits_d;
	assign coin_lock_enable = credits_d < CREDIT_LIMIT;
	assign coins_taken      = total_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= '0;
			total_q   <= '0;
			sound_q   <= '0;
		end else if (accept) begin
			credits_q <= credits_d;
			total_q   <= total_d;
			sound_q   <= sound_d;
		end
	end

endmodule

// ===== rtl/cscc_out_buf.sv =====
// two-entry result buffer between the tick logic and the output channel
// depends on cscc_pkg
module cscc_out_buf import cscc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    not_full,
	output logic    head_valid,
	input  logic    pop,
	output result_t head_data
);

	result_t     entry_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;

	assign not_full   = cnt_q != 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/coin_slot_credit_controller.sv =====
// Coin slot credit controller: takes one tick transaction per clock while in_ready is high and
// returns one result transaction for it. The per-tick state update is computed combinationally
// in two slot lanes and a merge stage; the result is registered into a two-entry output buffer,
// and the input stays ready while fewer than two results wait. Sustained rate is one transaction
// per clock whenever the output side keeps taking results.
// depends on cscc_pkg, cscc_lane, cscc_merge, cscc_out_buf
module coin_slot_credit_controller import cscc_pkg::*; #(
	parameter int HOLDOFF_TICKS = 120,
	parameter int PULSE_PERIOD  = 30,
	parameter int MAX_CREDITS   = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [ROW_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PAT_W-1:0]    slot_one_pattern,
	input  logic [PAT_W-1:0]    slot_two_pattern,
	input  logic [PAT_W-1:0]    service_pattern,
	input  logic                test_mode,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CREDIT_W-1:0] credit_count,
	output logic                counter_drive_one,
	output logic                counter_drive_two,
	output logic                coin_lock_enable,
	output logic                sound_pulse,
	output logic [TOTAL_W-1:0]  coins_taken
);

	logic [ROW_W-1:0] cost_one_q, cost_two_q;
	logic             two_start_q;
	logic             accept, step;
	lane_evt_t        evt_one, evt_two;
	result_t          res, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_one_q  <= '0;
			cost_two_q  <= '0;
			two_start_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SLOT_ONE_COST: cost_one_q  <= cfg_wdata;
				REG_SLOT_TWO_COST: cost_two_q  <= cfg_wdata;
				REG_TWO_TO_START:  two_start_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;
	assign step   = accept && !test_mode;

	cscc_lane #(.HOLDOFF_TICKS(HOLDOFF_TICKS), .PULSE_PERIOD(PULSE_PERIOD)) u_lane_one (
		.clk, .arst_n, .step, .pattern(slot_one_pattern), .cost_row(cost_one_q),
		.two_to_start(two_start_q), .evt(evt_one), .drive(res.counter_drive_one)
	);

	cscc_lane #(.HOLDOFF_TICKS(HOLDOFF_TICKS), .PULSE_PERIOD(PULSE_PERIOD)) u_lane_two (
		.clk, .arst_n, .step, .pattern(slot_two_pattern), .cost_row(cost_two_q),
		.two_to_start(two_start_q), .evt(evt_two), .drive(res.counter_drive_two)
	);

	cscc_merge #(.MAX_CREDITS(MAX_CREDITS)) u_merge (
		.clk, .arst_n, .accept, .step, .service_pattern, .evt_one, .evt_two,
		.credit_count(res.credit_count), .coin_lock_enable(res.coin_lock_enable),
		.sound_pulse(res.sound_pulse), .coins_taken(res.coins_taken)
	);

	cscc_out_buf u_out_buf (
		.clk, .arst_n, .push(accept), .push_data(res), .not_full(in_ready),
		.head_valid(out_valid), .pop(out_valid && out_ready), .head_data(head)
	);

	assign credit_count      = head.credit_count;
	assign counter_drive_one = head.counter_drive_one;
	assign counter_drive_two = head.counter_drive_two;
	assign coin_lock_enable  = head.coin_lock_enable;
	assign sound_pulse       = head.sound_pulse;
	assign coins_taken       = head.coins_taken;

endmodule

// ===== rtl/cscc_checker.sv =====
// port-level checks for the coin slot credit controller, bound to the top level
// depends on cscc_pkg and coin_slot_credit_controller_defines.svh
`include "coin_slot_credit_controller_defines.svh"

module cscc_checker import cscc_pkg::*; #(
	parameter int MAX_CREDITS = 9
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [CREDIT_W-1:0] credit_count,
	input logic                coin_lock_enable,
	input logic [TOTAL_W-1:0]  coins_taken
);

	localparam logic [CREDIT_W-1:0] CREDIT_LIMIT = CREDIT_W'(MAX_CREDITS);

	// input only stalls while results are waiting
	`CSCC_ASSERT_NOW(a_stall_needs_output, clk, arst_n, !in_ready, out_valid)

	`CSCC_ASSERT_NOW(a_credit_lock, clk, arst_n, out_valid,
		(credit_count <= CREDIT_LIMIT) && (coin_lock_enable == (credit_count < CREDIT_LIMIT)))

	`CSCC_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid)

	`CSCC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready,
		$stable(credit_count) && $stable(coins_taken))

endmodule

bind coin_slot_credit_controller cscc_checker #(.MAX_CREDITS(MAX_CREDITS)) u_cscc_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .credit_count(credit_count),
	.coin_lock_enable(coin_lock_enable), .coins_taken(coins_taken)
);
